// File: hdl/gis_pkg.sv
`default_nettype none
package gis_pkg;

	// widths
	localparam int TIMER_BITS = 16;
	localparam int CMP_W      = 33;
	localparam int TICK_W     = 16;
	localparam int CUR_W      = 11;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [TICK_W-1:0]     tick_t;
	typedef logic [CUR_W-1:0]      cur_t;

	// opcodes
	localparam logic [3:0] OP_TICK     = 4'd0;
	localparam logic [3:0] OP_INTAKE   = 4'd1;
	localparam logic [3:0] OP_PLACE    = 4'd2;
	localparam logic [3:0] OP_OVERRIDE = 4'd3;
	localparam logic [3:0] OP_SET_POS  = 4'd4;
	localparam logic [3:0] OP_SET_ACT  = 4'd5;
	localparam logic [3:0] OP_SET_WRST = 4'd6;
	localparam logic [3:0] OP_SET_PC   = 4'd7;
	localparam logic [3:0] OP_MODE_RST = 4'd8;

	// actions
	localparam logic [1:0] ACT_IDLE = 2'd0;
	localparam logic [1:0] ACT_IN   = 2'd1;
	localparam logic [1:0] ACT_OUT  = 2'd2;

	// jaw positions
	localparam logic [1:0] POS_OPEN  = 2'd0;
	localparam logic [1:0] POS_AGAPE = 2'd1;
	localparam logic [1:0] POS_AJAR  = 2'd2;

	// pieces
	localparam logic [1:0] PC_NONE = 2'd0;
	localparam logic [1:0] PC_CONE = 2'd1;
	localparam logic [1:0] PC_CUBE = 2'd2;

	// arg value that is out of range for position, action and piece
	localparam logic [1:0] ARG_BAD = 2'd3;

	// match modes
	localparam logic [1:0] MODE_DISABLED = 2'd0;
	localparam logic [1:0] MODE_AUTO     = 2'd1;
	localparam logic [1:0] MODE_TELEOP   = 2'd2;

	// motor drive codes (two's complement)
	localparam logic [1:0] DRV_STOP = 2'b00;
	localparam logic [1:0] DRV_IN   = 2'b01;
	localparam logic [1:0] DRV_OUT  = 2'b11;

	// register indexes
	localparam logic [2:0] REG_CUBE_PLACE  = 3'd0;
	localparam logic [2:0] REG_CONE_PLACE  = 3'd1;
	localparam logic [2:0] REG_AUTO_INTAKE = 3'd2;
	localparam logic [2:0] REG_OPEN_LIMIT  = 3'd3;
	localparam logic [2:0] REG_AGAPE_LIMIT = 3'd4;
	localparam logic [2:0] REG_OPEN_SPIKE  = 3'd5;
	localparam logic [2:0] REG_AGAPE_SPIKE = 3'd6;

	typedef struct packed {
		tick_t cube_place_ticks;
		tick_t cone_place_ticks;
		tick_t auto_intake_ticks;
		cur_t  open_current_limit;
		cur_t  agape_current_limit;
		tick_t open_spike_ticks;
		tick_t agape_spike_ticks;
	} cfg_t;

	typedef struct packed {
		logic [3:0] opcode;
		logic [1:0] arg;
		logic [1:0] last_mode;
		cur_t       left_current;
		cur_t       right_current;
	} item_t;

	typedef struct packed {
		logic [1:0] drive;
		logic [2:0] pistons;
		logic [1:0] action;
		logic [1:0] position;
		logic [1:0] piece;
		logic       placing;
		logic       intake_done;
		logic       scored;
		logic       acquired;
	} result_t;

	function automatic timer_t sat_inc(input timer_t t);
		return (t == '1) ? t : t + timer_t'(1);
	endfunction

	function automatic logic [CMP_W-1:0] ext_timer(input timer_t t);
		return CMP_W'(t);
	endfunction

	function automatic logic [CMP_W-1:0] ext_tick(input tick_t t);
		return CMP_W'(t);
	endfunction

endpackage
`default_nettype wire

// File: hdl/gripper_intake_sequencer.sv
`default_nettype none
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready  | opcode, arg, last_mode, left_current,
//          |                      | right_current
// out      | out_valid/ out_ready | motor_drive, jaw_piston_one, jaw_piston_two,
//          |                      | wrist_extend, action_now, jaw_position,
//          |                      | held_piece, placing_busy, intake_done,
//          |                      | scored_pulse, acquired_pulse
// config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one transaction per cycle while out_ready holds; a result passes from the input register
// (loaded at acceptance) through the sequencer step into the result register
// the sequencer step is combinational flag and timer logic on the state registers
// arst_n clears the valid flags and the sequencer state and loads the register defaults
// a stalled result holds the result register; the input register still takes
// one more transaction, then in_ready drops until out_ready returns
module gripper_intake_sequencer
	import gis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [3:0]        opcode,
	input  wire logic [1:0]        arg,
	input  wire logic [1:0]        last_mode,
	input  wire logic [CUR_W-1:0]  left_current,
	input  wire logic [CUR_W-1:0]  right_current,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [1:0]      motor_drive,
	output logic                   jaw_piston_one,
	output logic                   jaw_piston_two,
	output logic                   wrist_extend,
	output logic [1:0]             action_now,
	output logic [1:0]             jaw_position,
	output logic [1:0]             held_piece,
	output logic                   placing_busy,
	output logic                   intake_done,
	output logic                   scored_pulse,
	output logic                   acquired_pulse,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_fire;

	gis_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake control
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode        <= opcode;
			item_s1.arg           <= arg;
			item_s1.last_mode     <= last_mode;
			item_s1.left_current  <= left_current;
			item_s1.right_current <= right_current;
		end
	end

	gis_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	// output fields
	assign out_valid      = valid_s2;
	assign motor_drive    = $signed(res_s2.drive);
	assign jaw_piston_one = res_s2.pistons[0];
	assign jaw_piston_two = res_s2.pistons[1];
	assign wrist_extend   = res_s2.pistons[2];
	assign action_now     = res_s2.action;
	assign jaw_position   = res_s2.position;
	assign held_piece     = res_s2.piece;
	assign placing_busy   = res_s2.placing;
	assign intake_done    = res_s2.intake_done;
	assign scored_pulse   = res_s2.scored;
	assign acquired_pulse = res_s2.acquired;

`ifndef SYNTHESIS
	// a completed placement leaves the gripper empty and not placing
	a_scored_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scored_pulse |-> !placing_busy && held_piece == PC_NONE)
		else $error("scored result still holds a piece or is placing");

	// an acquire always leaves a piece in the jaw
	a_acquired_piece: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && acquired_pulse |-> held_piece != PC_NONE && !scored_pulse)
		else $error("acquired result without a piece");

	// a waiting transaction in the input register is not dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a transaction");

	// a step always loads the result register
	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("sequencer step did not produce a result");
`endif

endmodule
`default_nettype wire

// File: hdl/gis_cfg_regs.sv
`default_nettype none
module gis_cfg_regs
	import gis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cube_place_ticks    <= tick_t'(25);
			cfg_q.cone_place_ticks    <= tick_t'(13);
			cfg_q.auto_intake_ticks   <= tick_t'(25);
			cfg_q.open_current_limit  <= cur_t'(200);
			cfg_q.agape_current_limit <= cur_t'(180);
			cfg_q.open_spike_ticks    <= tick_t'(10);
			cfg_q.agape_spike_ticks   <= tick_t'(7);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CUBE_PLACE:  cfg_q.cube_place_ticks    <= pwdata[TICK_W-1:0];
				REG_CONE_PLACE:  cfg_q.cone_place_ticks    <= pwdata[TICK_W-1:0];
				REG_AUTO_INTAKE: cfg_q.auto_intake_ticks   <= pwdata[TICK_W-1:0];
				REG_OPEN_LIMIT:  cfg_q.open_current_limit  <= pwdata[CUR_W-1:0];
				REG_AGAPE_LIMIT: cfg_q.agape_current_limit <= pwdata[CUR_W-1:0];
				REG_OPEN_SPIKE:  cfg_q.open_spike_ticks    <= pwdata[TICK_W-1:0];
				REG_AGAPE_SPIKE: cfg_q.agape_spike_ticks   <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_CUBE_PLACE:  prdata = DATA_W'(cfg_q.cube_place_ticks);
			REG_CONE_PLACE:  prdata = DATA_W'(cfg_q.cone_place_ticks);
			REG_AUTO_INTAKE: prdata = DATA_W'(cfg_q.auto_intake_ticks);
			REG_OPEN_LIMIT:  prdata = DATA_W'(cfg_q.open_current_limit);
			REG_AGAPE_LIMIT: prdata = DATA_W'(cfg_q.agape_current_limit);
			REG_OPEN_SPIKE:  prdata = DATA_W'(cfg_q.open_spike_ticks);
			REG_AGAPE_SPIKE: prdata = DATA_W'(cfg_q.agape_spike_ticks);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/gis_core.sv
`default_nettype none
module gis_core
	import gis_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  advance,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    result
);

	// sequencer state
	logic [1:0] action_q, position_q, piece_q, drive_q;
	logic       placing_q, auto_q, finishing_q, tipped_q, spike_run_q;
	timer_t     place_tmr_q, auto_tmr_q, spike_tmr_q;
	logic [2:0] pistons_q;

	logic [1:0] action_n, position_n, piece_n, drive_n;
	logic       placing_n, auto_n, finishing_n, tipped_n, spike_run_n;
	timer_t     place_tmr_n, auto_tmr_n, spike_tmr_n;
	logic [2:0] pistons_n;
	logic       scored, acquired;

	timer_t     spike_adv;
	logic       is_open, is_agape, spike, keep_piece;

	// next state for one transaction
	always_comb begin
		action_n    = action_q;
		position_n  = position_q;
		piece_n     = piece_q;
		drive_n     = drive_q;
		placing_n   = placing_q;
		auto_n      = auto_q;
		finishing_n = finishing_q;
		tipped_n    = tipped_q;
		spike_run_n = spike_run_q;
		place_tmr_n = place_tmr_q;
		auto_tmr_n  = auto_tmr_q;
		spike_tmr_n = spike_tmr_q;
		pistons_n   = pistons_q;
		scored      = 1'b0;
		acquired    = 1'b0;
		is_open     = 1'b0;
		is_agape    = 1'b0;
		spike       = 1'b0;
		spike_adv   = spike_run_q ? sat_inc(spike_tmr_q) : spike_tmr_q;
		keep_piece  = (item.arg == MODE_DISABLED && item.last_mode == MODE_AUTO) ||
			(item.arg == MODE_TELEOP && item.last_mode == MODE_DISABLED);

		unique case (item.opcode)
			OP_TICK: begin
				place_tmr_n = sat_inc(place_tmr_q);
				auto_tmr_n  = sat_inc(auto_tmr_q);
				spike_tmr_n = spike_adv;

				// placement, requested intake, or finishing an acquire
				if (placing_q) begin
					if (piece_q == PC_CUBE) begin
						if (ext_timer(place_tmr_n) >= ext_tick(cfg.cube_place_ticks)) begin
							placing_n = 1'b0;
							action_n  = ACT_IDLE;
							piece_n   = PC_NONE;
							scored    = 1'b1;
						end else begin
							action_n = ACT_OUT;
						end
					end else if (piece_q == PC_CONE) begin
						if (ext_timer(place_tmr_n) >= ext_tick(cfg.cone_place_ticks)) begin
							placing_n = 1'b0;
							action_n  = ACT_IDLE;
							piece_n   = PC_NONE;
							scored    = 1'b1;
						end else begin
							position_n = POS_OPEN;
						end
					end else begin
						placing_n = 1'b0;
					end
				end else if (auto_q) begin
					if (ext_timer(auto_tmr_n) >= ext_tick(cfg.auto_intake_ticks)) begin
						auto_n   = 1'b0;
						action_n = ACT_IDLE;
					end else begin
						action_n = ACT_IN;
					end
				end else if (finishing_q) begin
					finishing_n = 1'b0;
					action_n    = ACT_IDLE;
					acquired    = 1'b1;
					if (position_q == POS_OPEN) begin
						piece_n = PC_CUBE;
					end else begin
						piece_n    = PC_CONE;
						position_n = POS_AJAR;
					end
				end

				// motor drive and current spike detection
				is_open  = position_n == POS_OPEN;
				is_agape = position_n == POS_AGAPE;
				spike    = (is_open && (item.left_current >= cfg.open_current_limit ||
						item.right_current >= cfg.open_current_limit)) ||
					(is_agape && (item.left_current >= cfg.agape_current_limit ||
						item.right_current >= cfg.agape_current_limit));
				if (action_n == ACT_IN) begin
					drive_n = DRV_IN;
					if (spike) begin
						if (!spike_run_q) begin
							spike_run_n = 1'b1;
							spike_tmr_n = '0;
						end
						if ((is_open &&
								ext_timer(spike_tmr_n) > ext_tick(cfg.open_spike_ticks)) ||
							(is_agape &&
								ext_timer(spike_tmr_n) > ext_tick(cfg.agape_spike_ticks))) begin
							finishing_n = 1'b1;
						end
					end else begin
						spike_tmr_n = '0;
						spike_run_n = 1'b0;
					end
				end else if (action_n == ACT_OUT) begin
					drive_n = DRV_OUT;
				end else begin
					drive_n = DRV_STOP;
				end

				// pistons follow jaw position and wrist flag
				pistons_n[0] = is_open || is_agape;
				pistons_n[1] = is_open;
				pistons_n[2] = tipped_q;
			end
			OP_INTAKE: begin
				auto_n     = 1'b1;
				auto_tmr_n = '0;
			end
			OP_PLACE: begin
				if (piece_q != PC_NONE) begin
					placing_n   = 1'b1;
					place_tmr_n = '0;
				end
			end
			OP_OVERRIDE: begin
				placing_n = 1'b0;
				if (item.arg != 2'd0) begin
					if (piece_q == PC_NONE) begin
						if (position_q == POS_OPEN) begin
							piece_n  = PC_CUBE;
							acquired = 1'b1;
						end else if (position_q == POS_AGAPE) begin
							piece_n    = PC_CONE;
							position_n = POS_AJAR;
							acquired   = 1'b1;
						end
					end
				end else begin
					piece_n = PC_NONE;
				end
			end
			OP_SET_POS: begin
				if (item.arg != ARG_BAD) position_n = item.arg;
			end
			OP_SET_ACT: begin
				if (item.arg != ARG_BAD) action_n = item.arg;
			end
			OP_SET_WRST: begin
				tipped_n = item.arg != 2'd0;
			end
			OP_SET_PC: begin
				if (item.arg != ARG_BAD) piece_n = item.arg;
			end
			OP_MODE_RST: begin
				action_n  = ACT_IDLE;
				drive_n   = DRV_STOP;
				placing_n = 1'b0;
				if (!keep_piece) begin
					piece_n  = PC_NONE;
					tipped_n = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q    <= ACT_IDLE;
			position_q  <= POS_OPEN;
			piece_q     <= PC_NONE;
			drive_q     <= DRV_STOP;
			placing_q   <= 1'b0;
			auto_q      <= 1'b0;
			finishing_q <= 1'b0;
			tipped_q    <= 1'b0;
			spike_run_q <= 1'b0;
			place_tmr_q <= '0;
			auto_tmr_q  <= '0;
			spike_tmr_q <= '0;
			pistons_q   <= '0;
		end else if (advance) begin
			action_q    <= action_n;
			position_q  <= position_n;
			piece_q     <= piece_n;
			drive_q     <= drive_n;
			placing_q   <= placing_n;
			auto_q      <= auto_n;
			finishing_q <= finishing_n;
			tipped_q    <= tipped_n;
			spike_run_q <= spike_run_n;
			place_tmr_q <= place_tmr_n;
			auto_tmr_q  <= auto_tmr_n;
			spike_tmr_q <= spike_tmr_n;
			pistons_q   <= pistons_n;
		end
	end

	// status after the transaction
	always_comb begin
		result.drive       = drive_n;
		result.pistons     = pistons_n;
		result.action      = action_n;
		result.position    = position_n;
		result.piece       = piece_n;
		result.placing     = placing_n;
		result.intake_done = !auto_n;
		result.scored      = scored;
		result.acquired    = acquired;
	end

endmodule
`default_nettype wire

// File: bench/gripper_intake_sequencer_tb.sv
`default_nettype none
module gripper_intake_sequencer_tb
	import gis_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// block ports
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [3:0]        opcode = '0;
	logic [1:0]        arg = '0;
	logic [1:0]        last_mode = '0;
	cur_t              left_current = '0;
	cur_t              right_current = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [1:0] motor_drive;
	logic              jaw_piston_one;
	logic              jaw_piston_two;
	logic              wrist_extend;
	logic [1:0]        action_now;
	logic [1:0]        jaw_position;
	logic [1:0]        held_piece;
	logic              placing_busy;
	logic              intake_done;
	logic              scored_pulse;
	logic              acquired_pulse;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gripper_intake_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .arg(arg), .last_mode(last_mode),
		.left_current(left_current), .right_current(right_current),
		.out_valid(out_valid), .out_ready(out_ready),
		.motor_drive(motor_drive), .jaw_piston_one(jaw_piston_one),
		.jaw_piston_two(jaw_piston_two), .wrist_extend(wrist_extend),
		.action_now(action_now), .jaw_position(jaw_position),
		.held_piece(held_piece), .placing_busy(placing_busy),
		.intake_done(intake_done), .scored_pulse(scored_pulse),
		.acquired_pulse(acquired_pulse),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// stimulus waiting to be sent and status words waiting to come back
	item_t   pending_items[$];
	result_t status_due[$];

	int n_in = 0;
	int n_out = 0;
	int n_bad = 0;
	int n_writes = 0;
	int n_scored = 0;
	int n_acquired = 0;

	// mirror of the register file, loaded with the reset defaults
	cfg_t cfg_mirror = '{
		cube_place_ticks: 16'd25, cone_place_ticks: 16'd13,
		auto_intake_ticks: 16'd25, open_current_limit: 11'd200,
		agape_current_limit: 11'd180, open_spike_ticks: 16'd10,
		agape_spike_ticks: 16'd7
	};

	// mirror of the sequencer state
	logic [1:0] act_m = ACT_IDLE;
	logic [1:0] pos_m = POS_OPEN;
	logic [1:0] piece_m = PC_NONE;
	logic       placing_m = 1'b0;
	logic       auto_run = 1'b0;
	logic       finishing = 1'b0;
	logic       tipped = 1'b0;
	timer_t     place_cnt = '0;
	timer_t     auto_cnt = '0;
	timer_t     spike_cnt = '0;
	logic       spike_on = 1'b0;
	logic [1:0] drv_m = DRV_STOP;
	logic [2:0] pist_m = '0;

	// one sequencer step: update the mirrored state, return the status word
	function automatic result_t advance_gripper(input item_t it);
		result_t r;
		logic scored, acquired, open_jaw, agape_jaw, hot;
		scored = 1'b0;
		acquired = 1'b0;
		case (it.opcode)
		OP_TICK: begin
			if (place_cnt != '1) place_cnt = place_cnt + 1'b1;
			if (auto_cnt != '1) auto_cnt = auto_cnt + 1'b1;
			if (spike_on && spike_cnt != '1) spike_cnt = spike_cnt + 1'b1;
			// placement, then requested intake, then piece classification
			if (placing_m) begin
				if (piece_m == PC_CUBE) begin
					if (place_cnt >= cfg_mirror.cube_place_ticks) begin
						placing_m = 1'b0;
						act_m = ACT_IDLE;
						piece_m = PC_NONE;
						scored = 1'b1;
					end else
						act_m = ACT_OUT;
				end else if (piece_m == PC_CONE) begin
					if (place_cnt >= cfg_mirror.cone_place_ticks) begin
						placing_m = 1'b0;
						act_m = ACT_IDLE;
						piece_m = PC_NONE;
						scored = 1'b1;
					end else
						pos_m = POS_OPEN;
				end else
					placing_m = 1'b0;
			end else if (auto_run) begin
				if (auto_cnt >= cfg_mirror.auto_intake_ticks) begin
					auto_run = 1'b0;
					act_m = ACT_IDLE;
				end else
					act_m = ACT_IN;
			end else if (finishing) begin
				finishing = 1'b0;
				act_m = ACT_IDLE;
				if (pos_m == POS_OPEN)
					piece_m = PC_CUBE;
				else begin
					piece_m = PC_CONE;
					pos_m = POS_AJAR;
				end
				acquired = 1'b1;
			end
			// motor command and current spike watch
			open_jaw = (pos_m == POS_OPEN);
			agape_jaw = (pos_m == POS_AGAPE);
			if (act_m == ACT_IN) begin
				hot = (open_jaw && (it.left_current >= cfg_mirror.open_current_limit ||
					it.right_current >= cfg_mirror.open_current_limit)) ||
					(agape_jaw && (it.left_current >= cfg_mirror.agape_current_limit ||
					it.right_current >= cfg_mirror.agape_current_limit));
				drv_m = DRV_IN;
				if (hot) begin
					if (!spike_on) begin
						spike_on = 1'b1;
						spike_cnt = '0;
					end
					if ((open_jaw && spike_cnt > cfg_mirror.open_spike_ticks) ||
						(agape_jaw && spike_cnt > cfg_mirror.agape_spike_ticks))
						finishing = 1'b1;
				end else begin
					spike_cnt = '0;
					spike_on = 1'b0;
				end
			end else if (act_m == ACT_OUT)
				drv_m = DRV_OUT;
			else
				drv_m = DRV_STOP;
			pist_m = {tipped, pos_m == POS_OPEN, pos_m != POS_AJAR};
		end
		OP_INTAKE: begin
			auto_run = 1'b1;
			auto_cnt = '0;
		end
		OP_PLACE: begin
			if (piece_m != PC_NONE) begin
				placing_m = 1'b1;
				place_cnt = '0;
			end
		end
		OP_OVERRIDE: begin
			placing_m = 1'b0;
			if (it.arg != 2'd0) begin
				if (piece_m == PC_NONE) begin
					if (pos_m == POS_OPEN) begin
						piece_m = PC_CUBE;
						acquired = 1'b1;
					end else if (pos_m == POS_AGAPE) begin
						piece_m = PC_CONE;
						pos_m = POS_AJAR;
						acquired = 1'b1;
					end
				end
			end else
				piece_m = PC_NONE;
		end
		OP_SET_POS: if (it.arg != ARG_BAD) pos_m = it.arg;
		OP_SET_ACT: if (it.arg != ARG_BAD) act_m = it.arg;
		OP_SET_WRST: tipped = (it.arg != 2'd0);
		OP_SET_PC: if (it.arg != ARG_BAD) piece_m = it.arg;
		OP_MODE_RST: begin
			act_m = ACT_IDLE;
			drv_m = DRV_STOP;
			placing_m = 1'b0;
			// disabled after auto and teleop after disabled keep the piece
			if (!(it.arg == MODE_DISABLED && it.last_mode == MODE_AUTO) &&
				!(it.arg == MODE_TELEOP && it.last_mode == MODE_DISABLED)) begin
				piece_m = PC_NONE;
				tipped = 1'b0;
			end
		end
		default: ;
		endcase
		r.drive = drv_m;
		r.pistons = pist_m;
		r.action = act_m;
		r.position = pos_m;
		r.piece = piece_m;
		r.placing = placing_m;
		r.intake_done = !auto_run;
		r.scored = scored;
		r.acquired = acquired;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		n_bad++;
	endtask

	task automatic check_field(input string name, input logic [1:0] got,
		input logic [1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				n_out, name, got, want));
	endtask

	// wait before the next transaction: mostly short, sometimes long
	function automatic int draw_wait();
		if ($urandom_range(2, 0) == 0)
			return $urandom_range(16, 0);
		return $urandom_range(1, 0);
	endfunction

	// input driver
	logic send_burst = 1'b0;
	int   gap_left = 0;

	always @(posedge clk) begin : drive_in
		item_t nxt, seen;
		int g;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if ($urandom_range(39, 0) == 0) send_burst = !send_burst;
			if (in_valid && in_ready) begin
				seen = {opcode, arg, last_mode, left_current, right_current};
				status_due.push_back(advance_gripper(seen));
				n_in++;
				g = send_burst ? 0 : draw_wait();
				if (g == 0 && pending_items.size() != 0) begin
					nxt = pending_items.pop_front();
					opcode <= nxt.opcode;
					arg <= nxt.arg;
					last_mode <= nxt.last_mode;
					left_current <= nxt.left_current;
					right_current <= nxt.right_current;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					gap_left <= g;
				end
			end else if (!in_valid) begin
				if (gap_left != 0)
					gap_left <= gap_left - 1;
				else if (pending_items.size() != 0) begin
					nxt = pending_items.pop_front();
					opcode <= nxt.opcode;
					arg <= nxt.arg;
					last_mode <= nxt.last_mode;
					left_current <= nxt.left_current;
					right_current <= nxt.right_current;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// result monitor with random backpressure
	logic recv_burst = 1'b0;
	int   stall_left = 0;

	always @(posedge clk) begin : watch_out
		result_t want;
		int w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if ($urandom_range(39, 0) == 0) recv_burst = !recv_burst;
			if (out_valid && out_ready) begin
				if (status_due.size() == 0)
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						n_out));
				else begin
					want = status_due.pop_front();
					check_field("motor_drive", motor_drive, want.drive);
					check_field("jaw_piston_one", jaw_piston_one, want.pistons[0]);
					check_field("jaw_piston_two", jaw_piston_two, want.pistons[1]);
					check_field("wrist_extend", wrist_extend, want.pistons[2]);
					check_field("action_now", action_now, want.action);
					check_field("jaw_position", jaw_position, want.position);
					check_field("held_piece", held_piece, want.piece);
					check_field("placing_busy", placing_busy, want.placing);
					check_field("intake_done", intake_done, want.intake_done);
					check_field("scored_pulse", scored_pulse, want.scored);
					check_field("acquired_pulse", acquired_pulse, want.acquired);
				end
				if (scored_pulse === 1'b1) n_scored++;
				if (acquired_pulse === 1'b1) n_acquired++;
				n_out++;
				w = recv_burst ? 0 : draw_wait();
				if (w == 0)
					out_ready <= 1'b1;
				else begin
					out_ready <= 1'b0;
					stall_left <= w;
				end
			end else if (!out_ready) begin
				if (stall_left > 1)
					stall_left <= stall_left - 1;
				else begin
					stall_left <= 0;
					out_ready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	int quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("gripper_intake_sequencer_tb: FAIL");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// register write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_CUBE_PLACE: cfg_mirror.cube_place_ticks = val[TICK_W-1:0];
		REG_CONE_PLACE: cfg_mirror.cone_place_ticks = val[TICK_W-1:0];
		REG_AUTO_INTAKE: cfg_mirror.auto_intake_ticks = val[TICK_W-1:0];
		REG_OPEN_LIMIT: cfg_mirror.open_current_limit = val[CUR_W-1:0];
		REG_AGAPE_LIMIT: cfg_mirror.agape_current_limit = val[CUR_W-1:0];
		REG_OPEN_SPIKE: cfg_mirror.open_spike_ticks = val[TICK_W-1:0];
		REG_AGAPE_SPIKE: cfg_mirror.agape_spike_ticks = val[TICK_W-1:0];
		default: ;
		endcase
		n_writes++;
	endtask

	task automatic program_all(input cfg_t c);
		write_reg(REG_CUBE_PLACE, DATA_W'(c.cube_place_ticks));
		write_reg(REG_CONE_PLACE, DATA_W'(c.cone_place_ticks));
		write_reg(REG_AUTO_INTAKE, DATA_W'(c.auto_intake_ticks));
		write_reg(REG_OPEN_LIMIT, DATA_W'(c.open_current_limit));
		write_reg(REG_AGAPE_LIMIT, DATA_W'(c.agape_current_limit));
		write_reg(REG_OPEN_SPIKE, DATA_W'(c.open_spike_ticks));
		write_reg(REG_AGAPE_SPIKE, DATA_W'(c.agape_spike_ticks));
	endtask

	// short timings so that placements and spikes finish within a sequence
	task automatic random_cfg(output cfg_t c);
		c.cube_place_ticks = TICK_W'($urandom_range(30, 0));
		c.cone_place_ticks = TICK_W'($urandom_range(30, 0));
		c.auto_intake_ticks = TICK_W'($urandom_range(30, 0));
		c.open_current_limit = CUR_W'($urandom_range(2000, 0));
		c.agape_current_limit = CUR_W'($urandom_range(2000, 0));
		c.open_spike_ticks = TICK_W'($urandom_range(12, 0));
		c.agape_spike_ticks = TICK_W'($urandom_range(12, 0));
	endtask

	// wait until every expected result is back and the block is quiet
	task automatic settle();
		while (pending_items.size() != 0 || status_due.size() != 0 || in_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [1:0] rand2();
		return 2'($urandom_range(3, 0));
	endfunction

	function automatic cur_t any_current();
		return CUR_W'($urandom_range(2000, 0));
	endfunction

	// a current at or above the limit when hot, below it otherwise (zero for a zero limit)
	function automatic cur_t pick_current(input logic hot, input cur_t lim);
		if (hot) return CUR_W'($urandom_range(2000, lim));
		if (lim == '0) return '0;
		return CUR_W'($urandom_range(lim - 1, 0));
	endfunction

	task automatic queue_item(input logic [3:0] op, input logic [1:0] a,
		input logic [1:0] lm, input cur_t l, input cur_t r);
		item_t it;
		it.opcode = op;
		it.arg = a;
		it.last_mode = lm;
		it.left_current = l;
		it.right_current = r;
		pending_items.push_back(it);
	endtask

	task automatic queue_cmd(input logic [3:0] op, input logic [1:0] a);
		queue_item(op, a, rand2(), any_current(), any_current());
	endtask

	task automatic queue_tick(input cur_t l, input cur_t r);
		queue_item(OP_TICK, rand2(), rand2(), l, r);
	endtask

	// one random sequence; mostly well-formed intakes and placements
	task automatic random_sequence(output int used);
		logic [1:0] jaw;
		logic [3:0] op;
		cur_t lim;
		int n, hold_for, k, side;
		logic hot;
		used = 0;
		case ($urandom_range(9, 0))
		0, 1, 2, 3: begin
			// intake with a current spike that should classify the piece
			jaw = ($urandom_range(7, 0) == 0) ? POS_AJAR :
				($urandom_range(1, 0) ? POS_AGAPE : POS_OPEN);
			queue_cmd(OP_SET_POS, jaw);
			if ($urandom_range(1, 0)) queue_cmd(OP_SET_WRST, rand2());
			if ($urandom_range(2, 0) == 0) begin
				queue_cmd(OP_SET_ACT, ACT_IN);
				hold_for = 0;
			end else begin
				queue_cmd(OP_INTAKE, rand2());
				hold_for = (cfg_mirror.auto_intake_ticks > 30) ? 32 :
					int'(cfg_mirror.auto_intake_ticks) + 2;
			end
			lim = (jaw == POS_OPEN) ? cfg_mirror.open_current_limit :
				cfg_mirror.agape_current_limit;
			n = (jaw == POS_OPEN) ? int'(cfg_mirror.open_spike_ticks) :
				int'(cfg_mirror.agape_spike_ticks);
			if (n > 30) n = 30;
			n = n + $urandom_range(8, 1);
			if (n < hold_for) n = hold_for;
			for (k = 0; k < n; k++) begin
				hot = ($urandom_range(7, 0) != 0);
				side = $urandom_range(2, 0);
				queue_tick(pick_current(hot && side != 1, lim),
					pick_current(hot && side != 0, lim));
			end
			used = n + 2;
		end
		4, 5, 6: begin
			// placement, now and then disturbed by another command
			if ($urandom_range(3, 0) == 0) begin
				queue_cmd(OP_SET_PC, PC_NONE);
				queue_cmd(OP_SET_POS, $urandom_range(1, 0) ? POS_AGAPE : POS_OPEN);
				queue_cmd(OP_OVERRIDE, 2'($urandom_range(3, 1)));
				used = 3;
			end else begin
				queue_cmd(OP_SET_PC, $urandom_range(1, 0) ? PC_CUBE : PC_CONE);
				used = 1;
			end
			if ($urandom_range(2, 0) == 0) queue_cmd(OP_SET_WRST, rand2());
			queue_cmd(OP_PLACE, rand2());
			n = (cfg_mirror.cube_place_ticks > cfg_mirror.cone_place_ticks) ?
				int'(cfg_mirror.cube_place_ticks) : int'(cfg_mirror.cone_place_ticks);
			if (n > 35) n = 35;
			n = n + $urandom_range(3, 0);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(24, 0) == 0)
					queue_item(4'($urandom_range(8, 1)), rand2(), rand2(),
						any_current(), any_current());
				else
					queue_tick(any_current(), any_current());
			end
			used = used + n + 1;
		end
		7: begin
			// mode change, sometimes while the motors run
			if ($urandom_range(1, 0)) begin
				queue_cmd(OP_SET_ACT, $urandom_range(1, 0) ? ACT_OUT : ACT_IN);
				queue_tick(any_current(), any_current());
				used = 2;
			end
			queue_item(OP_MODE_RST, rand2(), rand2(), any_current(), any_current());
			queue_tick(any_current(), any_current());
			used = used + 2;
		end
		default: begin
			// noise, unused opcodes included
			n = $urandom_range(4, 1);
			for (k = 0; k < n; k++) begin
				op = 4'($urandom_range(15, 0));
				queue_item(op, rand2(), rand2(), any_current(), any_current());
				if (op <= OP_MODE_RST) used++;
			end
		end
		endcase
	endtask

	task automatic run_random(input int goal);
		int total, u;
		total = 0;
		while (total < goal) begin
			random_sequence(u);
			total = total + u;
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset defaults
		queue_tick('0, '0);
		queue_item(4'd15, 2'd3, 2'd3, 11'd2000, 11'd2000);
		queue_item(4'd9, 2'd0, 2'd0, '0, '0);
		queue_cmd(OP_PLACE, 2'd0);
		queue_cmd(OP_SET_POS, ARG_BAD);
		queue_cmd(OP_SET_ACT, ARG_BAD);
		queue_cmd(OP_SET_PC, ARG_BAD);
		queue_cmd(OP_SET_WRST, 2'd1);
		queue_cmd(OP_SET_POS, POS_AGAPE);
		queue_cmd(OP_OVERRIDE, 2'd1);
		queue_cmd(OP_OVERRIDE, 2'd2);
		queue_cmd(OP_PLACE, 2'd0);
		queue_cmd(OP_SET_PC, PC_NONE);
		queue_tick('0, '0);
		queue_cmd(OP_SET_PC, PC_CUBE);
		queue_cmd(OP_PLACE, 2'd3);
		queue_tick(11'd2000, 11'd2000);
		queue_cmd(OP_OVERRIDE, 2'd0);
		queue_cmd(OP_INTAKE, 2'd0);
		queue_cmd(OP_SET_ACT, ACT_IN);
		queue_tick(11'd2000, '0);
		queue_tick('0, 11'd2000);
		queue_item(OP_MODE_RST, MODE_DISABLED, MODE_AUTO, '0, '0);
		queue_item(OP_MODE_RST, MODE_TELEOP, MODE_DISABLED, '0, '0);
		queue_item(OP_MODE_RST, MODE_AUTO, MODE_TELEOP, '0, '0);

		// random phases over several register settings
		settle();
		random_cfg(c);
		program_all(c);
		@(negedge clk);
		run_random(250);

		settle();
		program_all('0);
		@(negedge clk);
		run_random(150);

		settle();
		c.cube_place_ticks = '1;
		c.cone_place_ticks = '1;
		c.auto_intake_ticks = '1;
		c.open_current_limit = 11'd2000;
		c.agape_current_limit = 11'd2000;
		c.open_spike_ticks = '1;
		c.agape_spike_ticks = '1;
		program_all(c);
		@(negedge clk);
		run_random(150);

		settle();
		random_cfg(c);
		program_all(c);
		@(negedge clk);
		run_random(250);

		settle();
		random_cfg(c);
		program_all(c);
		@(negedge clk);
		run_random(200);

		settle();
		repeat (10) @(negedge clk);
		$display("run covered %0d transactions in, %0d results checked, %0d register writes",
			n_in, n_out, n_writes);
		$display("pieces placed %0d, pieces acquired %0d, mismatches %0d",
			n_scored, n_acquired, n_bad);
		if (n_bad == 0)
			$display("gripper_intake_sequencer_tb: PASS");
		else
			$display("gripper_intake_sequencer_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
